// ===== rtl/core/gtem_pkg.sv =====
// ----------------------------------------------------------------------------
// gtem_pkg
// shared widths, constants, register indexes and types of the edge map block
// ----------------------------------------------------------------------------
`default_nettype none

package gtem_pkg;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MIN_DIM       = 3;
  localparam int MAX_HEIGHT    = 4096;

  localparam logic [PIX_W-1:0] EDGE_VALUE = 8'd255;
  localparam logic [PIX_W-1:0] FLAT_VALUE = 8'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd8;
  localparam logic [FW_W-1:0]  WIDTH_RST     = 11'd640;
  localparam logic [FH_W-1:0]  HEIGHT_RST    = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  typedef struct packed {
    logic interior;
    logic frame_end;
  } pos_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/gtem_line_store.sv =====
// ----------------------------------------------------------------------------
// gtem_line_store
// one-row pixel memory, read-before-write on a single port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module gtem_line_store
  import gtem_pkg::*;
#(
  parameter int DEPTH  = MAX_WIDTH_DEF,
  parameter int ADDR_W = $clog2(MAX_WIDTH_DEF)
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [PIX_W-1:0]  wr_data,
  output logic      [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  // old contents come out, new pixel goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r  <= mem[addr];
      mem[addr]  <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/gtem_position.sv =====
// ----------------------------------------------------------------------------
// gtem_position
// column and row counters with clamped frame size, border and end-of-frame flags
// ----------------------------------------------------------------------------
`default_nettype none

module gtem_position
  import gtem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COL_W     = $clog2(MAX_WIDTH_DEF)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic [FW_W-1:0]  frame_width,
  input  wire logic [FH_W-1:0]  frame_height,
  output logic      [COL_W-1:0] col,
  output pos_flags_t            flags
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WW > FW_W) ? WW : FW_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CMP_W-1:0] fw_ext, w_eff, w_last;
  logic [FH_W-1:0]  h_eff;
  logic [ROW_W-1:0] h_last;
  logic             last_col, last_row;

  always_comb begin
    fw_ext = CMP_W'(frame_width);
    if (fw_ext < CMP_W'(MIN_DIM)) begin
      w_eff = CMP_W'(MIN_DIM);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    w_last = w_eff - CMP_W'(1);

    if (frame_height < FH_W'(MIN_DIM)) begin
      h_eff = FH_W'(MIN_DIM);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    h_last = ROW_W'(h_eff - FH_W'(1));
  end

  // counters past a shrunken size count as sitting on the last position
  assign last_col = CMP_W'(col_r) >= w_last;
  assign last_row = row_r >= h_last;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col             = col_r;
  assign flags.interior  = (col_r != '0) && (row_r != '0) && !last_col && !last_row;
  assign flags.frame_end = last_col && last_row;

endmodule

`default_nettype wire

// ===== rtl/core/gtem_classify.sv =====
// ----------------------------------------------------------------------------
// gtem_classify
// edge decision from the differences to the pixel above and to the left
// ----------------------------------------------------------------------------
`default_nettype none

module gtem_classify
  import gtem_pkg::*;
(
  input  wire logic [PIX_W-1:0] pixel,
  input  wire logic [PIX_W-1:0] above,
  input  wire logic [PIX_W-1:0] left,
  input  wire logic [THR_W-1:0] threshold,
  input  wire logic             interior,
  output logic      [PIX_W-1:0] result
);

  logic [PIX_W-1:0] diff_up, diff_left;

  always_comb begin
    diff_up   = (pixel > above) ? pixel - above : above - pixel;
    diff_left = (pixel > left)  ? pixel - left  : left - pixel;
    if (!interior) begin
      result = pixel;
    end else if (diff_up > threshold || diff_left > threshold) begin
      result = EDGE_VALUE;
    end else begin
      result = FLAT_VALUE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gradient_threshold_edge_map.sv =====
// ----------------------------------------------------------------------------
// gradient_threshold_edge_map
// path: an input beat passes through the stage 1 register, then the output register
// throughput: one pixel per clock while out_tready does not stall the output, set by
//   the line store's one read and one write per cycle on a single port
// reset: synchronous on rst_n, clears counters, valid flags and the left pixel,
//   loads threshold 8, width 640, height 480; the line store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_threshold_edge_map
  import gtem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // pixel input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] gray_pixel
  // edge map output stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [7:0]            out_tdata,  // [7:0] out_pixel
  output logic                       out_tlast   // frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // configuration registers
  logic [THR_W-1:0] threshold_r;
  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THRESHOLD_RST;
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_r    <= cfg_wdata[THR_W-1:0];
        REG_WIDTH:     frame_width_r  <= cfg_wdata[FW_W-1:0];
        REG_HEIGHT:    frame_height_r <= cfg_wdata[FH_W-1:0];
        default: begin
          // unknown index, ignored
        end
      endcase
    end
  end

  // handshake: stage 1 holds the accepted pixel while the line store read lands,
  // the output register holds the finished result
  logic in_beat;
  logic out_free;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_beat) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // raster position of the incoming pixel
  logic [COL_W-1:0] col;
  pos_flags_t       pos_flags;

  gtem_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_position (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_beat),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .col          (col),
    .flags        (pos_flags)
  );

  // pixel above comes out in the cycle after the beat, same column is overwritten
  logic [PIX_W-1:0] above;

  gtem_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .en      (in_beat),
    .addr    (col),
    .wr_data (in_tdata[PIX_W-1:0]),
    .rd_data (above)
  );

  // left neighbor register
  logic [PIX_W-1:0] left_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_pixel_r <= '0;
    end else if (in_beat) begin
      left_pixel_r <= in_tdata[PIX_W-1:0];
    end
  end

  // stage 1 payload
  logic [PIX_W-1:0] s1_pixel_r;
  logic [PIX_W-1:0] s1_left_r;
  pos_flags_t       s1_flags_r;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_pixel_r <= in_tdata[PIX_W-1:0];
      s1_left_r  <= left_pixel_r;
      s1_flags_r <= pos_flags;
    end
  end

  // edge decision
  logic [PIX_W-1:0] result;

  gtem_classify u_classify (
    .pixel     (s1_pixel_r),
    .above     (above),
    .left      (s1_left_r),
    .threshold (threshold_r),
    .interior  (s1_flags_r.interior),
    .result    (result)
  );

  // output register
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_pixel_r <= result;
      out_last_r  <= s1_flags_r.frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== sim/tb_gradient_threshold_edge_map.sv =====
// ----------------------------------------------------------------------------
// tb_gradient_threshold_edge_map
// self-checking bench for the edge map block: a scoreboard class predicts every
// output beat from the accepted pixels and register writes; frames of many
// sizes and thresholds run through with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gradient_threshold_edge_map;
  import gtem_pkg::*;

  localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
  localparam int IDLE_LIMIT    = 2000;   // cycles with no beat on either side
  localparam int RANDOM_PIXELS = 700;
  localparam int SETTLE_CYCLES = 4;      // pipeline is two deep, leave some margin
  localparam int REPORT_MAX    = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to no register

  // predicts the edge map and holds the beats still owed by the block
  class edge_map_scoreboard;
    typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
    } edge_beat_t;

    logic [PIX_W-1:0] line_row [LINE_DEPTH];
    logic [PIX_W-1:0] left_pix;
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [THR_W-1:0] threshold;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    edge_beat_t       expected_beats[$];
    int               mismatches;
    int               beats_seen;

    function new();
      foreach (line_row[i]) line_row[i] = '0;
      left_pix   = '0;
      col_pos    = 0;
      row_pos    = 0;
      threshold  = THRESHOLD_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function int unsigned active_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned active_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function bit at_frame_start();
      return col_pos == 0 && row_pos == 0;
    endfunction

    // pixels still needed to close the current frame, with the clamp rule for
    // counters that sit past a shrunken last position
    function int unsigned pixels_to_frame_end();
      int unsigned w, h, in_row, rows_left;
      w = active_width();
      h = active_height();
      in_row    = (col_pos >= w - 1) ? 1 : w - col_pos;
      rows_left = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
      return in_row + rows_left * w;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD: threshold  = data[THR_W-1:0];
        REG_WIDTH:     width_reg  = data[FW_W-1:0];
        REG_HEIGHT:    height_reg = data[FH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned w, h;
      bit          last_col, last_row;
      int          dv, dh;
      edge_beat_t  beat;
      w = active_width();
      h = active_height();
      last_col   = col_pos >= w - 1;
      last_row   = row_pos >= h - 1;
      beat.pixel = pix;
      if (col_pos != 0 && row_pos != 0 && !last_col && !last_row) begin
        dv = int'(pix) - int'(line_row[col_pos]);
        dh = int'(pix) - int'(left_pix);
        if (dv < 0) dv = -dv;
        if (dh < 0) dh = -dh;
        beat.pixel = (dv > int'(threshold) || dh > int'(threshold)) ? EDGE_VALUE : FLAT_VALUE;
      end
      beat.frame_end    = last_col && last_row;
      line_row[col_pos] = pix;
      left_pix          = pix;
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
      expected_beats.push_back(beat);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_beat(logic [PIX_W-1:0] pix, logic last);
      edge_beat_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        flag($sformatf("beat %0d: unexpected, got pixel %0d last %0b", beats_seen, pix, last));
        return;
      end
      want = expected_beats.pop_front();
      if (want.pixel !== pix || want.frame_end !== last)
        flag($sformatf("beat %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                       beats_seen, want.pixel, want.frame_end, pix, last));
    endfunction
  endclass

  // ports of the block, every input known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [7:0] gray_pixel
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // [7:0] out_pixel
  logic                  out_tlast;         // frame_end

  edge_map_scoreboard edge_sb = new();
  bit                 quiet;        // phase with no gaps and no stalls
  int                 stall_left;
  int                 idle_run;

  always #2 clk = ~clk;

  gradient_threshold_edge_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // plain random, plateaus with noise around the threshold, or near-extremes
  function automatic logic [7:0] make_pixel(int mode, int base, int spread);
    int v;
    case (mode)
      0:       v = int'($urandom_range(255));
      1:       v = base + int'($urandom_range(2 * spread)) - spread;
      default: v = ($urandom_range(1) == 1) ? 255 - int'($urandom_range(2))
                                             : int'($urandom_range(2));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // all beats and register writes are sampled here, in one fixed order
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) edge_sb.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) edge_sb.note_pixel(in_tdata);
      if (out_tvalid && out_tready) edge_sb.check_beat(out_tdata, out_tlast);
    end
  end

  // output side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(99) < 20) stall_left = pick_gap();
    end
  end

  // watchdog: a run of cycles with no beat at all means the block hung
  initial begin
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run = 0;
      else idle_run++;
    end
    $display("Mismatches found");
    $finish;
  end

  // one pixel beat, optionally after a gap; returns right after acceptance
  task automatic push_pixel(input logic [7:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom());
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_list(input logic [7:0] px[$]);
    foreach (px[i]) push_pixel(px[i]);
    in_tvalid <= 1'b0;
  endtask

  task automatic push_run(input int unsigned n);
    int mode, base, spread;
    mode   = $urandom_range(2);
    base   = $urandom_range(255);
    spread = int'(edge_sb.threshold) + 2;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) base = $urandom_range(255);  // new plateau
      push_pixel(make_pixel(mode, base, spread));
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // unused upper data bits get noise, the block must mask them
  task automatic set_threshold(input int v);
    cfg_write(REG_THRESHOLD, {5'($urandom()), 8'(v)});
  endtask

  task automatic set_width(input int v);
    cfg_write(REG_WIDTH, {2'($urandom()), 11'(v)});
  endtask

  task automatic set_height(input int v);
    cfg_write(REG_HEIGHT, 13'(v));
  endtask

  // drop the write enable and let the scoreboard see the last write
  task automatic close_config();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every owed beat is out, then let the pipeline go quiet
  task automatic settle();
    @(posedge clk);
    while (edge_sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned random_pixels;
    int unsigned n;
    int unsigned w, h;
    int          r;
    bit          mid;
    logic [7:0]  frame_a[$];
    logic [7:0]  frame_b[$];
    logic [7:0]  frame_c_head[$];
    logic [7:0]  frame_c_tail[$];

    // center 9 against neighbors 1: difference equals the threshold, so flat
    frame_a      = '{8'd255, 8'd1, 8'd0, 8'd1, 8'd9, 8'd255, 8'd0, 8'd255, 8'd7};
    // center 65 against 64 above: one step over a zero threshold is an edge
    frame_b      = '{8'd128, 8'd64, 8'd32, 8'd16, 8'd65, 8'd8, 8'd4, 8'd2, 8'd255};
    // full swing 0 to 255 never beats a threshold of 255
    frame_c_head = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
    frame_c_tail = '{8'd77, 8'd255, 8'd0, 8'd255};
    random_pixels = 0;
    quiet         = 1'b0;
    stall_left    = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // out-of-range low sizes clamp to 3x3, threshold stays at its reset value
    set_width(0);
    set_height(1);
    close_config();
    push_list(frame_a);
    settle();

    // zero threshold, exact minimum sizes, a write to an index with no register
    set_threshold(0);
    set_width(MIN_DIM);
    set_height(MIN_DIM);
    cfg_write(REG_SPARE, 13'($urandom()));
    close_config();
    push_list(frame_b);
    settle();

    // top threshold, and the width shrinks in the middle of row one so the
    // column counter sits on the new last column and wraps there
    set_threshold(255);
    set_width(4);
    close_config();
    push_list(frame_c_head);
    settle();
    set_width(MIN_DIM);
    close_config();
    push_list(frame_c_tail);
    settle();

    // --- random phases: mostly small frames, sometimes ending mid-frame ---
    while (random_pixels < RANDOM_PIXELS) begin
      quiet = ($urandom_range(4) == 0);
      mid   = !edge_sb.at_frame_start();
      if ($urandom_range(3) != 0) begin
        r = $urandom_range(9);
        set_threshold(r == 0 ? 0 : r == 1 ? 255 :
                      r < 6 ? int'($urandom_range(24)) : int'($urandom_range(255)));
      end
      if (mid) begin
        // inside a frame the row may only get shorter, never longer
        if ($urandom_range(2) == 0) set_width($urandom_range(MIN_DIM, edge_sb.active_width()));
      end else if ($urandom_range(3) != 0) begin
        r = $urandom_range(19);
        set_width(r == 0 ? int'($urandom_range(2)) :
                  r < 16 ? int'($urandom_range(3, 10)) : int'($urandom_range(11, 40)));
      end
      if ($urandom_range(2) != 0) begin
        r = $urandom_range(19);
        set_height(r == 0 ? int'($urandom_range(2)) :
                   r < 17 ? int'($urandom_range(3, 6)) : int'($urandom_range(7, 16)));
      end
      if ($urandom_range(9) == 0) cfg_write(REG_SPARE, 13'($urandom()));
      close_config();

      w = edge_sb.active_width();
      h = edge_sb.active_height();
      n = edge_sb.pixels_to_frame_end() + ($urandom_range(1) * w * h);
      if ($urandom_range(3) == 0) n += $urandom_range(1, w * h - 1);
      push_run(n);
      random_pixels += n;
      settle();
    end

    // --- largest sizes, a few frames only ---
    quiet = 1'b0;
    if (!edge_sb.at_frame_start()) begin
      push_run(edge_sb.pixels_to_frame_end());
      settle();
    end

    // width register all ones clamps to the line store depth, so row zero is
    // the widest row the line store holds; cut short after a few pixels of
    // row one by shrinking the width
    set_width(2047);
    set_height(MIN_DIM);
    close_config();
    push_run(LINE_DEPTH + 6);
    settle();
    set_width(MIN_DIM);
    close_config();
    push_run(edge_sb.pixels_to_frame_end());
    settle();

    // height beyond the limit, then the limit itself, then a shrink that
    // turns the current row into the last one
    set_height(8191);
    close_config();
    push_run(60);
    settle();
    set_height(MAX_HEIGHT);
    close_config();
    push_run(30);
    settle();
    set_height(MIN_DIM);
    close_config();
    push_run(edge_sb.pixels_to_frame_end());
    settle();

    repeat (10) @(posedge clk);
    if (edge_sb.mismatches == 0 && edge_sb.expected_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
